### rtl/pkf_pkg.sv
package pkf_pkg;

    // Operations of the arithmetic sequencer.
    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_GDIV = 3'd3,
        OP_CDIV = 3'd4,
        OP_END  = 3'd5
    } t_op;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SAMPLE_PERIOD = 2'd0;
    localparam logic [1:0] CFG_PROC_NOISE    = 2'd1;
    localparam logic [1:0] CFG_INIT_ACC_VAR  = 2'd2;

    localparam int PC_W      = 7;
    localparam int NUM_STATE = 9;

    localparam logic [PC_W-1:0] UPD_START  = 7'd0;
    localparam logic [PC_W-1:0] INIT_START = 7'd80;

    // Per-axis scratch file locations. The first nine hold filter state.
    localparam logic [5:0] RG_POS  = 6'd0;
    localparam logic [5:0] RG_VEL  = 6'd1;
    localparam logic [5:0] RG_ACC  = 6'd2;
    localparam logic [5:0] RG_PP   = 6'd3;
    localparam logic [5:0] RG_PV   = 6'd4;
    localparam logic [5:0] RG_PA   = 6'd5;
    localparam logic [5:0] RG_VV   = 6'd6;
    localparam logic [5:0] RG_VA   = 6'd7;
    localparam logic [5:0] RG_AA   = 6'd8;
    localparam logic [5:0] RG_TS2  = 6'd9;
    localparam logic [5:0] RG_TS3  = 6'd10;
    localparam logic [5:0] RG_TS4  = 6'd11;
    localparam logic [5:0] RG_TS5  = 6'd12;
    localparam logic [5:0] RG_T3   = 6'd13;
    localparam logic [5:0] RG_T2   = 6'd14;
    localparam logic [5:0] RG_M11  = 6'd15;
    localparam logic [5:0] RG_M12  = 6'd16;
    localparam logic [5:0] RG_M13  = 6'd17;
    localparam logic [5:0] RG_M22  = 6'd18;
    localparam logic [5:0] RG_M23  = 6'd19;
    localparam logic [5:0] RG_M33  = 6'd20;
    localparam logic [5:0] RG_BOT  = 6'd21;
    localparam logic [5:0] RG_K1   = 6'd22;
    localparam logic [5:0] RG_K2   = 6'd23;
    localparam logic [5:0] RG_K3   = 6'd24;
    localparam logic [5:0] RG_FACT = 6'd25;
    localparam logic [5:0] RG_PR   = 6'd26;
    localparam logic [5:0] RG_RES  = 6'd27;
    localparam logic [5:0] RG_X    = 6'd28;
    localparam logic [5:0] RG_Y    = 6'd29;

    // Operand sources that do not live in the scratch file.
    localparam logic [5:0] SP_ZERO = 6'd32;
    localparam logic [5:0] SP_ONE  = 6'd33;
    localparam logic [5:0] SP_TS   = 6'd34;
    localparam logic [5:0] SP_PHIN = 6'd35;
    localparam logic [5:0] SP_Z    = 6'd36;
    localparam logic [5:0] SP_R2   = 6'd37;
    localparam logic [5:0] SP_V0   = 6'd38;
    localparam logic [5:0] SP_IAV  = 6'd39;
    localparam logic [5:0] SP_C2   = 6'd40;
    localparam logic [5:0] SP_C3   = 6'd41;
    localparam logic [5:0] SP_C6   = 6'd42;
    localparam logic [5:0] SP_C8   = 6'd43;
    localparam logic [5:0] SP_C20  = 6'd44;

    typedef struct packed {
        t_op        op;
        logic [4:0] dst;
        logic [5:0] sa;
        logic [5:0] sb;
    } t_instr;

    function automatic t_instr mk(t_op op, logic [5:0] d, logic [5:0] a, logic [5:0] b);
        t_instr i;
        i.op  = op;
        i.dst = d[4:0];
        i.sa  = a;
        i.sb  = b;
        return i;
    endfunction

    // Microprogram: measurement update for one axis, then the init load.
    function automatic t_instr prog(logic [PC_W-1:0] pc);
        t_instr i;
        case (pc)
            7'd0:  i = mk(OP_MUL,  RG_TS2,  SP_TS,   SP_TS);
            7'd1:  i = mk(OP_MUL,  RG_TS3,  RG_TS2,  SP_TS);
            7'd2:  i = mk(OP_MUL,  RG_TS4,  RG_TS3,  SP_TS);
            7'd3:  i = mk(OP_MUL,  RG_TS5,  RG_TS4,  SP_TS);
            7'd4:  i = mk(OP_MUL,  RG_X,    SP_TS,   RG_VA);
            7'd5:  i = mk(OP_ADD,  RG_T3,   RG_PA,   RG_X);
            7'd6:  i = mk(OP_MUL,  RG_X,    RG_TS2,  RG_AA);
            7'd7:  i = mk(OP_CDIV, RG_X,    RG_X,    SP_C2);
            7'd8:  i = mk(OP_ADD,  RG_T3,   RG_T3,   RG_X);
            7'd9:  i = mk(OP_MUL,  RG_X,    SP_TS,   RG_VV);
            7'd10: i = mk(OP_ADD,  RG_T2,   RG_PV,   RG_X);
            7'd11: i = mk(OP_MUL,  RG_X,    RG_TS2,  RG_VA);
            7'd12: i = mk(OP_CDIV, RG_X,    RG_X,    SP_C2);
            7'd13: i = mk(OP_ADD,  RG_T2,   RG_T2,   RG_X);
            7'd14: i = mk(OP_MUL,  RG_X,    SP_TS,   RG_PV);
            7'd15: i = mk(OP_ADD,  RG_M11,  RG_PP,   RG_X);
            7'd16: i = mk(OP_MUL,  RG_X,    RG_TS2,  RG_PA);
            7'd17: i = mk(OP_CDIV, RG_X,    RG_X,    SP_C2);
            7'd18: i = mk(OP_ADD,  RG_M11,  RG_M11,  RG_X);
            7'd19: i = mk(OP_MUL,  RG_X,    SP_TS,   RG_T2);
            7'd20: i = mk(OP_ADD,  RG_M11,  RG_M11,  RG_X);
            7'd21: i = mk(OP_MUL,  RG_X,    RG_TS2,  RG_T3);
            7'd22: i = mk(OP_CDIV, RG_X,    RG_X,    SP_C2);
            7'd23: i = mk(OP_ADD,  RG_M11,  RG_M11,  RG_X);
            7'd24: i = mk(OP_MUL,  RG_X,    RG_TS5,  SP_PHIN);
            7'd25: i = mk(OP_CDIV, RG_X,    RG_X,    SP_C20);
            7'd26: i = mk(OP_ADD,  RG_M11,  RG_M11,  RG_X);
            7'd27: i = mk(OP_MUL,  RG_X,    SP_TS,   RG_T3);
            7'd28: i = mk(OP_ADD,  RG_M12,  RG_T2,   RG_X);
            7'd29: i = mk(OP_MUL,  RG_X,    RG_TS4,  SP_PHIN);
            7'd30: i = mk(OP_CDIV, RG_X,    RG_X,    SP_C8);
            7'd31: i = mk(OP_ADD,  RG_M12,  RG_M12,  RG_X);
            7'd32: i = mk(OP_MUL,  RG_X,    SP_PHIN, RG_TS3);
            7'd33: i = mk(OP_CDIV, RG_X,    RG_X,    SP_C6);
            7'd34: i = mk(OP_ADD,  RG_M13,  RG_T3,   RG_X);
            7'd35: i = mk(OP_MUL,  RG_X,    SP_TS,   RG_VA);
            7'd36: i = mk(OP_ADD,  RG_M22,  RG_VV,   RG_X);
            7'd37: i = mk(OP_MUL,  RG_X,    SP_TS,   RG_AA);
            7'd38: i = mk(OP_ADD,  RG_X,    RG_VA,   RG_X);
            7'd39: i = mk(OP_MUL,  RG_X,    SP_TS,   RG_X);
            7'd40: i = mk(OP_ADD,  RG_M22,  RG_M22,  RG_X);
            7'd41: i = mk(OP_MUL,  RG_X,    SP_PHIN, RG_TS3);
            7'd42: i = mk(OP_CDIV, RG_X,    RG_X,    SP_C3);
            7'd43: i = mk(OP_ADD,  RG_M22,  RG_M22,  RG_X);
            7'd44: i = mk(OP_MUL,  RG_X,    SP_TS,   RG_AA);
            7'd45: i = mk(OP_ADD,  RG_M23,  RG_VA,   RG_X);
            7'd46: i = mk(OP_MUL,  RG_X,    RG_TS2,  SP_PHIN);
            7'd47: i = mk(OP_CDIV, RG_X,    RG_X,    SP_C2);
            7'd48: i = mk(OP_ADD,  RG_M23,  RG_M23,  RG_X);
            7'd49: i = mk(OP_MUL,  RG_X,    SP_PHIN, SP_TS);
            7'd50: i = mk(OP_ADD,  RG_M33,  RG_AA,   RG_X);
            7'd51: i = mk(OP_ADD,  RG_BOT,  RG_M11,  SP_R2);
            7'd52: i = mk(OP_GDIV, RG_K1,   RG_M11,  RG_BOT);
            7'd53: i = mk(OP_GDIV, RG_K2,   RG_M12,  RG_BOT);
            7'd54: i = mk(OP_GDIV, RG_K3,   RG_M13,  RG_BOT);
            7'd55: i = mk(OP_SUB,  RG_FACT, SP_ONE,  RG_K1);
            7'd56: i = mk(OP_MUL,  RG_PP,   RG_FACT, RG_M11);
            7'd57: i = mk(OP_MUL,  RG_PV,   RG_FACT, RG_M12);
            7'd58: i = mk(OP_MUL,  RG_PA,   RG_FACT, RG_M13);
            7'd59: i = mk(OP_MUL,  RG_X,    RG_K2,   RG_M12);
            7'd60: i = mk(OP_SUB,  RG_VV,   RG_M22,  RG_X);
            7'd61: i = mk(OP_MUL,  RG_X,    RG_K2,   RG_M13);
            7'd62: i = mk(OP_SUB,  RG_VA,   RG_M23,  RG_X);
            7'd63: i = mk(OP_MUL,  RG_X,    RG_K3,   RG_M13);
            7'd64: i = mk(OP_SUB,  RG_AA,   RG_M33,  RG_X);
            7'd65: i = mk(OP_MUL,  RG_X,    SP_TS,   RG_VEL);
            7'd66: i = mk(OP_ADD,  RG_PR,   RG_POS,  RG_X);
            7'd67: i = mk(OP_MUL,  RG_X,    RG_TS2,  RG_ACC);
            7'd68: i = mk(OP_CDIV, RG_X,    RG_X,    SP_C2);
            7'd69: i = mk(OP_ADD,  RG_PR,   RG_PR,   RG_X);
            7'd70: i = mk(OP_SUB,  RG_RES,  SP_Z,    RG_PR);
            7'd71: i = mk(OP_MUL,  RG_X,    RG_K1,   RG_RES);
            7'd72: i = mk(OP_ADD,  RG_POS,  RG_X,    RG_PR);
            7'd73: i = mk(OP_MUL,  RG_X,    RG_K2,   RG_RES);
            7'd74: i = mk(OP_ADD,  RG_X,    RG_X,    RG_VEL);
            7'd75: i = mk(OP_MUL,  RG_Y,    SP_TS,   RG_ACC);
            7'd76: i = mk(OP_ADD,  RG_VEL,  RG_X,    RG_Y);
            7'd77: i = mk(OP_MUL,  RG_X,    RG_K3,   RG_RES);
            7'd78: i = mk(OP_ADD,  RG_ACC,  RG_X,    RG_ACC);
            7'd80: i = mk(OP_ADD,  RG_POS,  SP_Z,    SP_ZERO);
            7'd81: i = mk(OP_ADD,  RG_VEL,  SP_V0,   SP_ZERO);
            7'd82: i = mk(OP_ADD,  RG_ACC,  SP_ZERO, SP_ZERO);
            7'd83: i = mk(OP_ADD,  RG_PP,   SP_R2,   SP_ZERO);
            7'd84: i = mk(OP_ADD,  RG_PV,   SP_ZERO, SP_ZERO);
            7'd85: i = mk(OP_ADD,  RG_PA,   SP_ZERO, SP_ZERO);
            7'd86: i = mk(OP_ADD,  RG_VV,   SP_ZERO, SP_ZERO);
            7'd87: i = mk(OP_ADD,  RG_VA,   SP_ZERO, SP_ZERO);
            7'd88: i = mk(OP_ADD,  RG_AA,   SP_IAV,  SP_ZERO);
            default: i = mk(OP_END, SP_ZERO, SP_ZERO, SP_ZERO);
        endcase
        return i;
    endfunction

    // Two's complement magnitude; the most negative value maps to 2^63.
    function automatic logic [63:0] mag(logic [63:0] x);
        return x[63] ? (64'd0 - x) : x;
    endfunction

    // Applies a sign to a magnitude with saturation. Bit 64 flags saturation.
    function automatic logic [64:0] from_mag(logic [63:0] m, logic neg);
        logic [64:0] r;
        if (neg) begin
            if (m > 64'h8000_0000_0000_0000) begin
                r = {1'b1, 64'h8000_0000_0000_0000};
            end else begin
                r = {1'b0, 64'd0 - m};
            end
        end else begin
            if (m[63]) begin
                r = {1'b1, 64'h7FFF_FFFF_FFFF_FFFF};
            end else begin
                r = {1'b0, m};
            end
        end
        return r;
    endfunction

endpackage

### rtl/pkf_ram.sv
module pkf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/poly_kalman_filter_3state_2axis_core.sv
// Two independent position/velocity/acceleration Kalman filters, one per axis, in signed
// fixed point with FRAC_BITS fraction bits. A word with action 0 loads the initial state;
// a word with action 1 runs a full predict, gain and correct step on both axes. Every word
// yields one result word with the six estimates and a flag that is set when any operation
// of that step saturated. All arithmetic runs on one shared sequencer with a bit-serial
// multiplier and a bit-serial restoring divider, which runs more quotient steps for a gain
// than for a constant divide. One word is in work at a time; the next word is taken once
// the previous result has been placed in the output register, even if that result is
// still waiting to be taken.
module poly_kalman_filter_3state_2axis_core
    import pkf_pkg::*;
#(
    parameter int FRAC_BITS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [62:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_action,
    input  logic signed [63:0] i_meas_pos_x,
    input  logic signed [63:0] i_meas_pos_y,
    input  logic signed [63:0] i_init_vel_x,
    input  logic signed [63:0] i_init_vel_y,
    input  logic [62:0]        i_noise_var_x,
    input  logic [62:0]        i_noise_var_y,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [63:0] o_est_pos_x,
    output logic signed [63:0] o_est_vel_x,
    output logic signed [63:0] o_est_acc_x,
    output logic signed [63:0] o_est_pos_y,
    output logic signed [63:0] o_est_vel_y,
    output logic signed [63:0] o_est_acc_y,
    output logic               o_saturated
);

    localparam logic [63:0] ONE_Q    = 64'd1 << FRAC_BITS;
    localparam logic [63:0] HALF_LSB = 64'd1 << (FRAC_BITS - 1);
    localparam logic [63:0] TS_RST   = 64'd1 << FRAC_BITS;
    localparam logic [63:0] PHIN_RST = 64'd200 << FRAC_BITS;
    localparam logic [63:0] IAV_RST  = 64'd10000 << FRAC_BITS;
    localparam logic [63:0] S64_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN  = 64'h8000_0000_0000_0000;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_RDA  = 10'b00_0000_0010,
        ST_RDB  = 10'b00_0000_0100,
        ST_LDB  = 10'b00_0000_1000,
        ST_SET  = 10'b00_0001_0000,
        ST_MUL  = 10'b00_0010_0000,
        ST_RND  = 10'b00_0100_0000,
        ST_DIV  = 10'b00_1000_0000,
        ST_FIN  = 10'b01_0000_0000,
        ST_DONE = 10'b10_0000_0000
    } t_state;

    // Control state.
    t_state                r_state;
    logic [PC_W-1:0]       r_pc;
    logic [PC_W-1:0]       r_start;
    logic                  r_axis;
    logic                  r_sat;
    logic [1:0][NUM_STATE-1:0] r_vld;
    logic                  r_out_valid;
    logic [30:0]           r_ts;
    logic [62:0]           r_phin;
    logic [62:0]           r_iav;
    logic [63:0]           r_est_pos [2];
    logic [63:0]           r_est_vel [2];
    logic [63:0]           r_est_acc [2];

    // Datapath registers.
    logic [63:0] r_zx, r_zy, r_v0x, r_v0y;
    logic [62:0] r_r2x, r_r2y;
    logic [63:0] r_a, r_b;
    logic [63:0] r_hi, r_lo, r_mc, r_rem, r_q;
    logic [6:0]  r_cnt, r_last;
    logic        r_neg, r_over, r_dzero;
    logic [63:0] r_out_pos_x, r_out_vel_x, r_out_acc_x;
    logic [63:0] r_out_pos_y, r_out_vel_y, r_out_acc_y;
    logic        r_out_sat;

    t_instr      w_ins;
    logic [5:0]  w_rd_code, w_cap_code;
    logic [63:0] w_ram_q, w_spec, w_loc, w_opnd;
    logic        w_cap_vld;
    logic [63:0] w_mag_a, w_mag_b;
    logic [127:0] w_dd_g;
    logic [64:0] w_mul_sum;
    logic [64:0] w_rnd_sum;
    logic [64:0] w_rem2, w_rem_sub;
    logic        w_ge;
    logic [127:0] w_prod_sh;
    logic [64:0] w_fm_mul, w_fm_div, w_alu;
    logic [63:0] n_res;
    logic        n_sat;
    logic        w_ram_we;
    logic [5:0]  w_waddr, w_raddr;

    assign w_ins = prog(r_pc);

    // Scratch file address for the read issued now and the source captured now.
    assign w_rd_code  = (r_state == ST_RDB) ? w_ins.sb : w_ins.sa;
    assign w_cap_code = (r_state == ST_LDB) ? w_ins.sb : w_ins.sa;
    assign w_raddr    = {r_axis, w_rd_code[4:0]};
    assign w_waddr    = {r_axis, w_ins.dst};
    assign w_ram_we   = (r_state == ST_FIN);

    pkf_ram #(
        .WIDTH(64),
        .DEPTH(64)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(w_waddr),
        .i_wdata(n_res),
        .i_raddr(w_raddr),
        .o_rdata(w_ram_q)
    );

    // Filter state that was never written since reset reads as zero.
    assign w_cap_vld = (w_cap_code[4:0] < 5'(NUM_STATE)) ? r_vld[r_axis][w_cap_code[3:0]] : 1'b1;
    assign w_loc     = w_cap_vld ? w_ram_q : 64'd0;

    // Operands from inputs, registers and fixed divisors.
    always_comb begin
        case (w_cap_code)
            SP_ZERO: w_spec = 64'd0;
            SP_ONE:  w_spec = ONE_Q;
            SP_TS:   w_spec = {33'd0, r_ts};
            SP_PHIN: w_spec = {1'b0, r_phin};
            SP_Z:    w_spec = r_axis ? r_zy : r_zx;
            SP_R2:   w_spec = {1'b0, r_axis ? r_r2y : r_r2x};
            SP_V0:   w_spec = r_axis ? r_v0y : r_v0x;
            SP_IAV:  w_spec = {1'b0, r_iav};
            SP_C2:   w_spec = 64'd2;
            SP_C3:   w_spec = 64'd3;
            SP_C6:   w_spec = 64'd6;
            SP_C8:   w_spec = 64'd8;
            SP_C20:  w_spec = 64'd20;
            default: w_spec = 64'd0;
        endcase
    end

    assign w_opnd  = w_cap_code[5] ? w_spec : w_loc;
    assign w_mag_a = mag(r_a);
    assign w_mag_b = mag(r_b);
    assign w_dd_g  = {64'd0, w_mag_a} << FRAC_BITS;

    // One multiplier bit per cycle: conditional add, then shift right.
    assign w_mul_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mc} : 65'd0);
    assign w_rnd_sum = {1'b0, r_lo} + {1'b0, HALF_LSB};

    // One quotient bit per cycle of restoring division.
    assign w_rem2    = {r_rem, r_hi[63]};
    assign w_ge      = (w_rem2 >= {1'b0, r_mc});
    assign w_rem_sub = w_rem2 - {1'b0, r_mc};

    assign w_prod_sh = {r_hi, r_lo} >> FRAC_BITS;
    assign w_fm_mul  = from_mag(w_prod_sh[63:0], r_neg);
    assign w_fm_div  = from_mag(r_q, r_neg);

    // Result of the finished operation, saturated, with its saturation flag.
    always_comb begin
        w_alu = 65'd0;
        n_res = 64'd0;
        n_sat = 1'b0;
        case (w_ins.op)
            OP_ADD, OP_SUB: begin
                if (w_ins.op == OP_ADD) begin
                    w_alu = {r_a[63], r_a} + {r_b[63], r_b};
                end else begin
                    w_alu = {r_a[63], r_a} - {r_b[63], r_b};
                end
                if (w_alu[64] != w_alu[63]) begin
                    n_sat = 1'b1;
                    n_res = w_alu[64] ? S64_MIN : S64_MAX;
                end else begin
                    n_res = w_alu[63:0];
                end
            end
            OP_MUL: begin
                if (|w_prod_sh[127:64]) begin
                    n_sat = 1'b1;
                    n_res = r_neg ? S64_MIN : S64_MAX;
                end else begin
                    n_sat = w_fm_mul[64];
                    n_res = w_fm_mul[63:0];
                end
            end
            OP_GDIV, OP_CDIV: begin
                if (r_dzero) begin
                    n_res = 64'd0;
                end else if (r_over) begin
                    n_sat = 1'b1;
                    n_res = r_neg ? S64_MIN : S64_MAX;
                end else begin
                    n_sat = w_fm_div[64];
                    n_res = w_fm_div[63:0];
                end
            end
            default: begin
                n_res = 64'd0;
            end
        endcase
    end

    // Sequencer, configuration and filter state bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= UPD_START;
            r_start     <= UPD_START;
            r_axis      <= 1'b0;
            r_sat       <= 1'b0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
            r_ts        <= TS_RST[30:0];
            r_phin      <= PHIN_RST[62:0];
            r_iav       <= IAV_RST[62:0];
            r_est_pos   <= '{default: 64'd0};
            r_est_vel   <= '{default: 64'd0};
            r_est_acc   <= '{default: 64'd0};
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SAMPLE_PERIOD: r_ts   <= i_cfg_wdata[30:0];
                    CFG_PROC_NOISE:    r_phin <= i_cfg_wdata;
                    CFG_INIT_ACC_VAR:  r_iav  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            // A taken result clears the flag unless a new word is loaded at the same edge.
            if (r_out_valid && i_out_ready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_pc    <= i_action ? UPD_START : INIT_START;
                        r_start <= i_action ? UPD_START : INIT_START;
                        r_axis  <= 1'b0;
                        r_sat   <= 1'b0;
                        r_state <= ST_RDA;
                    end
                end
                ST_RDA: begin
                    if (w_ins.op == OP_END) begin
                        if (!r_axis) begin
                            r_axis <= 1'b1;
                            r_pc   <= r_start;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end else begin
                        r_state <= ST_RDB;
                    end
                end
                ST_RDB: r_state <= ST_LDB;
                ST_LDB: r_state <= ST_SET;
                ST_SET: begin
                    case (w_ins.op)
                        OP_MUL:  r_state <= ST_MUL;
                        OP_GDIV: r_state <= (w_mag_b == 64'd0) ? ST_FIN : ST_DIV;
                        OP_CDIV: r_state <= ST_DIV;
                        default: r_state <= ST_FIN;
                    endcase
                end
                ST_MUL: begin
                    if (r_cnt == 7'd63) begin
                        r_state <= ST_RND;
                    end
                end
                ST_RND: r_state <= ST_FIN;
                ST_DIV: begin
                    if (r_cnt == r_last) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_sat <= r_sat | n_sat;
                    if (w_ins.dst < 5'(NUM_STATE)) begin
                        r_vld[r_axis][w_ins.dst[3:0]] <= 1'b1;
                    end
                    case ({1'b0, w_ins.dst})
                        RG_POS:  r_est_pos[r_axis] <= n_res;
                        RG_VEL:  r_est_vel[r_axis] <= n_res;
                        RG_ACC:  r_est_acc[r_axis] <= n_res;
                        default: ;
                    endcase
                    r_pc    <= r_pc + 1'b1;
                    r_state <= ST_RDA;
                end
                ST_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Input capture, operand fetch, serial units and the output register.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_zx  <= i_meas_pos_x;
            r_zy  <= i_meas_pos_y;
            r_v0x <= i_init_vel_x;
            r_v0y <= i_init_vel_y;
            r_r2x <= i_noise_var_x;
            r_r2y <= i_noise_var_y;
        end
        case (r_state)
            ST_RDB: r_a <= w_opnd;
            ST_LDB: r_b <= w_opnd;
            ST_SET: begin
                r_cnt   <= 7'd0;
                r_neg   <= r_a[63] ^ r_b[63];
                r_over  <= 1'b0;
                r_dzero <= (w_ins.op == OP_GDIV) && (w_mag_b == 64'd0);
                r_rem   <= 64'd0;
                r_q     <= 64'd0;
                if (w_ins.op == OP_MUL) begin
                    r_hi <= 64'd0;
                    r_lo <= w_mag_b;
                    r_mc <= w_mag_a;
                end else if (w_ins.op == OP_GDIV) begin
                    r_hi   <= w_dd_g[127:64];
                    r_lo   <= w_dd_g[63:0];
                    r_mc   <= w_mag_b;
                    r_last <= 7'd127;
                end else begin
                    r_hi   <= w_mag_a;
                    r_lo   <= 64'd0;
                    r_mc   <= w_mag_b;
                    r_last <= 7'd63;
                end
            end
            ST_MUL: begin
                r_hi  <= w_mul_sum[64:1];
                r_lo  <= {w_mul_sum[0], r_lo[63:1]};
                r_cnt <= r_cnt + 1'b1;
            end
            ST_RND: begin
                r_lo <= w_rnd_sum[63:0];
                r_hi <= r_hi + {63'd0, w_rnd_sum[64]};
            end
            ST_DIV: begin
                r_rem  <= w_ge ? w_rem_sub[63:0] : w_rem2[63:0];
                r_over <= r_over | r_q[63];
                r_q    <= {r_q[62:0], w_ge};
                r_hi   <= {r_hi[62:0], r_lo[63]};
                r_lo   <= {r_lo[62:0], 1'b0};
                r_cnt  <= r_cnt + 1'b1;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    r_out_pos_x <= r_est_pos[0];
                    r_out_vel_x <= r_est_vel[0];
                    r_out_acc_x <= r_est_acc[0];
                    r_out_pos_y <= r_est_pos[1];
                    r_out_vel_y <= r_est_vel[1];
                    r_out_acc_y <= r_est_acc[1];
                    r_out_sat   <= r_sat;
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_est_pos_x = r_out_pos_x;
    assign o_est_vel_x = r_out_vel_x;
    assign o_est_acc_x = r_out_acc_x;
    assign o_est_pos_y = r_out_pos_y;
    assign o_est_vel_y = r_out_vel_y;
    assign o_est_acc_y = r_out_acc_y;
    assign o_saturated = r_out_sat;

endmodule

### rtl/pkf_checker.sv
module pkf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [63:0] o_est_pos_x,
    input logic        o_saturated
);

    // A taken word keeps the input side busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input side still ready right after a word was taken");

    // A new result appears only as the sequencer returns to waiting for input.
    a_result_at_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result raised while the sequencer was still busy");

    // With nothing taken and nothing pending, no result shows up.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && !i_in_valid && !o_out_valid) |=> !o_out_valid)
        else $error("result word produced without an input word");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_est_pos_x) && $stable(o_saturated)))
        else $error("stalled result word changed");

endmodule

bind poly_kalman_filter_3state_2axis_core pkf_checker u_pkf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_est_pos_x(o_est_pos_x),
    .o_saturated(o_saturated)
);

### tb/pkf_scoreboard.sv
`timescale 1ns / 100ps

module pkf_scoreboard
    import pkf_pkg::*;
#(
    parameter int FRAC_BITS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [62:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_action,
    input  logic signed [63:0] i_meas_pos_x,
    input  logic signed [63:0] i_meas_pos_y,
    input  logic signed [63:0] i_init_vel_x,
    input  logic signed [63:0] i_init_vel_y,
    input  logic [62:0]        i_noise_var_x,
    input  logic [62:0]        i_noise_var_y,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [63:0] i_est_pos_x,
    input  logic signed [63:0] i_est_vel_x,
    input  logic signed [63:0] i_est_acc_x,
    input  logic signed [63:0] i_est_pos_y,
    input  logic signed [63:0] i_est_vel_y,
    input  logic signed [63:0] i_est_acc_y,
    input  logic               i_saturated,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] UNITY   = 64'sd1 <<< FRAC_BITS;

    typedef struct packed {
        logic [63:0] pos_x;
        logic [63:0] vel_x;
        logic [63:0] acc_x;
        logic [63:0] pos_y;
        logic [63:0] vel_y;
        logic [63:0] acc_y;
        logic        sat;
    } t_estimate;

    // Settings and per-axis filter state, as the block should hold them.
    logic [62:0] period_q, noise_density_q, accel_var_q;
    logic signed [63:0] pos_q [2], vel_q [2], acc_q [2];
    logic signed [63:0] cpp_q [2], cpv_q [2], cpa_q [2], cvv_q [2], cva_q [2], caa_q [2];
    logic sat_seen;
    t_estimate est_queue [$];

    function automatic logic [63:0] abs64(logic [63:0] x);
        return x[63] ? (64'd0 - x) : x;
    endfunction

    // Signs a magnitude, clamping to the signed 64-bit range.
    function automatic logic signed [63:0] signed_clamp(logic [63:0] m, bit neg);
        if (neg) begin
            if (m > 64'h8000_0000_0000_0000) begin
                sat_seen = 1'b1;
                return S64_MIN;
            end
            return 64'd0 - m;
        end
        if (m[63]) begin
            sat_seen = 1'b1;
            return S64_MAX;
        end
        return m;
    endfunction

    function automatic logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            sat_seen = 1'b1;
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub(logic signed [63:0] a, logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) begin
            sat_seen = 1'b1;
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

    // Fixed-point product, rounded half away from zero.
    function automatic logic signed [63:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b);
        logic [127:0] p;
        bit neg;
        neg = a[63] ^ b[63];
        p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
        p = p + (128'd1 << (FRAC_BITS - 1));
        if (p[127:64+FRAC_BITS] != 0) begin
            sat_seen = 1'b1;
            return neg ? S64_MIN : S64_MAX;
        end
        return signed_clamp(p[63+FRAC_BITS:FRAC_BITS], neg);
    endfunction

    // Fixed-point gain quotient, truncated; a zero divisor gives zero.
    function automatic logic signed [63:0] fx_div(logic signed [63:0] a, logic signed [63:0] b);
        logic [127:0] num, q;
        bit neg;
        neg = a[63] ^ b[63];
        if (b == 0) return 64'sd0;
        num = {64'd0, abs64(a)} << FRAC_BITS;
        q = num / {64'd0, abs64(b)};
        if (q[127:64] != 0) begin
            sat_seen = 1'b1;
            return neg ? S64_MIN : S64_MAX;
        end
        return signed_clamp(q[63:0], neg);
    endfunction

    function automatic logic signed [63:0] int_div(logic signed [63:0] a, int n);
        return signed_clamp(abs64(a) / n, a[63]);
    endfunction

    // Predict, gain and correct one axis.
    task automatic track_axis(int ax, logic signed [63:0] z, logic signed [63:0] r2);
        logic signed [63:0] ts, phin, ts2, ts3, ts4, ts5, t3, t2;
        logic signed [63:0] m11, m12, m13, m22, m23, m33, bot, k1, k2, k3, fact, pr, res;
        ts   = {1'b0, period_q};
        phin = {1'b0, noise_density_q};
        ts2 = fx_mul(ts, ts);
        ts3 = fx_mul(ts2, ts);
        ts4 = fx_mul(ts3, ts);
        ts5 = fx_mul(ts4, ts);
        t3 = sat_add(sat_add(cpa_q[ax], fx_mul(ts, cva_q[ax])),
                     int_div(fx_mul(ts2, caa_q[ax]), 2));
        t2 = sat_add(sat_add(cpv_q[ax], fx_mul(ts, cvv_q[ax])),
                     int_div(fx_mul(ts2, cva_q[ax]), 2));
        m11 = sat_add(sat_add(sat_add(cpp_q[ax], fx_mul(ts, cpv_q[ax])),
                              int_div(fx_mul(ts2, cpa_q[ax]), 2)), fx_mul(ts, t2));
        m11 = sat_add(sat_add(m11, int_div(fx_mul(ts2, t3), 2)),
                      int_div(fx_mul(ts5, phin), 20));
        m12 = sat_add(sat_add(t2, fx_mul(ts, t3)), int_div(fx_mul(ts4, phin), 8));
        m13 = sat_add(t3, int_div(fx_mul(phin, ts3), 6));
        m22 = sat_add(sat_add(sat_add(cvv_q[ax], fx_mul(ts, cva_q[ax])),
                              fx_mul(ts, sat_add(cva_q[ax], fx_mul(ts, caa_q[ax])))),
                      int_div(fx_mul(phin, ts3), 3));
        m23 = sat_add(sat_add(cva_q[ax], fx_mul(ts, caa_q[ax])),
                      int_div(fx_mul(ts2, phin), 2));
        m33 = sat_add(caa_q[ax], fx_mul(phin, ts));
        bot = sat_add(m11, r2);
        k1 = '0;
        k2 = '0;
        k3 = '0;
        if (bot != 0) begin
            k1 = fx_div(m11, bot);
            k2 = fx_div(m12, bot);
            k3 = fx_div(m13, bot);
        end
        fact = sat_sub(UNITY, k1);
        cpp_q[ax] = fx_mul(fact, m11);
        cpv_q[ax] = fx_mul(fact, m12);
        cpa_q[ax] = fx_mul(fact, m13);
        cvv_q[ax] = sat_sub(m22, fx_mul(k2, m12));
        cva_q[ax] = sat_sub(m23, fx_mul(k2, m13));
        caa_q[ax] = sat_sub(m33, fx_mul(k3, m13));
        pr = sat_add(sat_add(pos_q[ax], fx_mul(ts, vel_q[ax])),
                     int_div(fx_mul(ts2, acc_q[ax]), 2));
        res = sat_sub(z, pr);
        pos_q[ax] = sat_add(fx_mul(k1, res), pr);
        vel_q[ax] = sat_add(sat_add(fx_mul(k2, res), vel_q[ax]), fx_mul(ts, acc_q[ax]));
        acc_q[ax] = sat_add(fx_mul(k3, res), acc_q[ax]);
    endtask

    // Applies one accepted word to both axes and queues the estimate it yields.
    task automatic predict_estimate();
        logic signed [63:0] z [2], v0 [2], r2 [2];
        t_estimate e;
        z[0] = i_meas_pos_x;
        z[1] = i_meas_pos_y;
        v0[0] = i_init_vel_x;
        v0[1] = i_init_vel_y;
        r2[0] = {1'b0, i_noise_var_x};
        r2[1] = {1'b0, i_noise_var_y};
        sat_seen = 1'b0;
        for (int ax = 0; ax < 2; ax++) begin
            if (!i_action) begin
                pos_q[ax] = z[ax];
                vel_q[ax] = v0[ax];
                acc_q[ax] = '0;
                cpp_q[ax] = r2[ax];
                cpv_q[ax] = '0;
                cpa_q[ax] = '0;
                cvv_q[ax] = '0;
                cva_q[ax] = '0;
                caa_q[ax] = {1'b0, accel_var_q};
            end else begin
                track_axis(ax, z[ax], r2[ax]);
            end
        end
        e = '{pos_q[0], vel_q[0], acc_q[0], pos_q[1], vel_q[1], acc_q[1], sat_seen};
        est_queue.push_back(e);
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            o_fail_count++;
            $display("%0t: mismatch on %s: expected %0d, actual %0d",
                     $time, name, $signed(exp_v), $signed(act_v));
        end
    endtask

    // Snoop configuration writes and both channels on each rising edge.
    always @(posedge i_clk) begin
        t_estimate e;
        if (!i_rst_n) begin
            period_q = 63'd16777216;
            noise_density_q = 63'd3355443200;
            accel_var_q = 63'd167772160000;
            for (int ax = 0; ax < 2; ax++) begin
                pos_q[ax] = '0; vel_q[ax] = '0; acc_q[ax] = '0;
                cpp_q[ax] = '0; cpv_q[ax] = '0; cpa_q[ax] = '0;
                cvv_q[ax] = '0; cva_q[ax] = '0; caa_q[ax] = '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SAMPLE_PERIOD: period_q = {32'd0, i_cfg_wdata[30:0]};
                    CFG_PROC_NOISE:    noise_density_q = i_cfg_wdata;
                    CFG_INIT_ACC_VAR:  accel_var_q = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (est_queue.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result word with no estimate waiting", $time);
                end else begin
                    e = est_queue.pop_front();
                    check_field("est_pos_x", e.pos_x, i_est_pos_x);
                    check_field("est_vel_x", e.vel_x, i_est_vel_x);
                    check_field("est_acc_x", e.acc_x, i_est_acc_x);
                    check_field("est_pos_y", e.pos_y, i_est_pos_y);
                    check_field("est_vel_y", e.vel_y, i_est_vel_y);
                    check_field("est_acc_y", e.acc_y, i_est_acc_y);
                    check_field("saturated", {63'd0, e.sat}, {63'd0, i_saturated});
                end
            end
            if (i_in_valid && i_in_ready) predict_estimate();
        end
        o_pending = est_queue.size();
    end

endmodule

### tb/poly_kalman_filter_3state_2axis_core_tb.sv
`timescale 1ns / 100ps

module poly_kalman_filter_3state_2axis_core_tb;
    import pkf_pkg::*;

    localparam int NUM_PHASES = 6;
    localparam int WORDS_PER_PHASE = 158;
    localparam int STALL_LIMIT = 100000;
    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
    localparam logic [62:0] U63_MAX = 63'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ONE_FX = 64'd16777216;

    logic i_clk, i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [62:0] i_cfg_wdata;
    logic i_in_valid, o_in_ready, i_action;
    logic signed [63:0] i_meas_pos_x, i_meas_pos_y, i_init_vel_x, i_init_vel_y;
    logic [62:0] i_noise_var_x, i_noise_var_y;
    logic o_out_valid, i_out_ready;
    logic signed [63:0] o_est_pos_x, o_est_vel_x, o_est_acc_x;
    logic signed [63:0] o_est_pos_y, o_est_vel_y, o_est_acc_y;
    logic o_saturated;
    int fail_count, pending;
    bit quiet, hold_req;

    poly_kalman_filter_3state_2axis_core dut (.*);

    pkf_scoreboard scoreboard (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_wdata,
        .i_in_valid, .i_in_ready(o_in_ready), .i_action,
        .i_meas_pos_x, .i_meas_pos_y, .i_init_vel_x, .i_init_vel_y,
        .i_noise_var_x, .i_noise_var_y,
        .i_out_valid(o_out_valid), .i_out_ready,
        .i_est_pos_x(o_est_pos_x), .i_est_vel_x(o_est_vel_x), .i_est_acc_x(o_est_acc_x),
        .i_est_pos_y(o_est_pos_y), .i_est_vel_y(o_est_vel_y), .i_est_acc_y(o_est_acc_y),
        .i_saturated(o_saturated),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: random back-pressure, or one long hold-off on request.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                i_out_ready = 1'b0;
                repeat (25000) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                i_out_ready = quiet || ($urandom_range(99) >= 28);
            end
        end
    end

    // Ends the run when neither channel moves for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic logic [63:0] pick_signed();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0: return S64_MAX;
            1: return S64_MIN;
            2: return 64'd0;
            3, 4: return {$urandom, $urandom};
            default: return {{32{r[31]}}, r} << $urandom_range(0, 24);
        endcase
    endfunction

    function automatic logic [62:0] pick_variance();
        case ($urandom_range(9))
            0: return U63_MAX;
            1: return 63'd0;
            2, 3: return 63'({$urandom, $urandom});
            default: return {31'd0, $urandom} << $urandom_range(0, 24);
        endcase
    endfunction

    // Offers one word and waits until the block takes it.
    task automatic send_word(logic act, logic [63:0] px, logic [63:0] py,
                             logic [63:0] vx, logic [63:0] vy,
                             logic [62:0] rx, logic [62:0] ry);
        if (!quiet && $urandom_range(99) < 28) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_action = act;
        i_meas_pos_x = px;
        i_meas_pos_y = py;
        i_init_vel_x = vx;
        i_init_vel_y = vy;
        i_noise_var_x = rx;
        i_noise_var_y = ry;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [62:0] data);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic random_word();
        int kind;
        kind = $urandom_range(99);
        if (kind < 12) begin
            send_word(1'b0, pick_signed(), pick_signed(), pick_signed(), pick_signed(),
                      pick_variance(), pick_variance());
        end else if (kind < 17) begin
            send_word(1'($urandom_range(1)), {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom},
                      63'({$urandom, $urandom}), 63'({$urandom, $urandom}));
        end else begin
            send_word(1'b1, pick_signed(), pick_signed(), {$urandom, $urandom},
                      {$urandom, $urandom}, pick_variance(), pick_variance());
        end
    endtask

    initial begin
        logic [62:0] periods [NUM_PHASES], densities [NUM_PHASES], accel_vars [NUM_PHASES];
        int words;
        periods    = '{63'd16777216, 63'd1, 63'd1677721600, 63'd1677722, 63'd0, 63'd16777216};
        densities  = '{63'd3355443200, 63'd0, U63_MAX, 63'd83886080, 63'd0, 63'd3355443200};
        accel_vars = '{63'd167772160000, U63_MAX, 63'd0, 63'd1677721600, 63'd0,
                       63'd167772160000};
        periods[4] = 63'($urandom_range(1, 1677721600));
        densities[4] = {31'd0, $urandom} << $urandom_range(0, 30);
        accel_vars[4] = 63'({$urandom, $urandom});
        words = 0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_SAMPLE_PERIOD;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_action = 1'b0;
        i_meas_pos_x = '0;
        i_meas_pos_y = '0;
        i_init_vel_x = '0;
        i_init_vel_y = '0;
        i_noise_var_x = '0;
        i_noise_var_y = '0;
        quiet = 1'b0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // New settings only once every estimate has come back.
            if (ph > 0) begin
                i_in_valid = 1'b0;
                while (pending != 0) @(negedge i_clk);
                repeat (20) @(negedge i_clk);
                write_reg(CFG_SAMPLE_PERIOD, periods[ph]);
                write_reg(CFG_PROC_NOISE, densities[ph]);
                write_reg(CFG_INIT_ACC_VAR, accel_vars[ph]);
            end
            if (ph == 0) begin
                // Updates on the reset state, then field extremes.
                send_word(1'b1, 0, 0, 0, 0, 0, 0);
                send_word(1'b1, S64_MAX, S64_MIN, S64_MAX, S64_MIN, U63_MAX, 0);
                send_word(1'b0, S64_MAX, S64_MIN, S64_MIN, S64_MAX, U63_MAX, U63_MAX);
                send_word(1'b1, S64_MIN, S64_MAX, 0, 0, 0, U63_MAX);
                send_word(1'b1, 0, 0, 0, 0, U63_MAX, U63_MAX);
                send_word(1'b0, 100 * ONE_FX, -100 * ONE_FX, 5 * ONE_FX, -5 * ONE_FX,
                          63'd167772160, 63'd167772160);
                for (int i = 0; i < 6; i++)
                    send_word(1'b1, (100 + 5 * i) * ONE_FX, -(100 + 5 * i) * ONE_FX,
                              0, 0, 63'd167772160, 63'd167772160);
                words += 12;
            end
            if (ph == 1) begin
                // No process noise and zero variances: the gain denominator is zero.
                write_reg(CFG_INIT_ACC_VAR, 63'd0);
                send_word(1'b0, 0, 0, 0, 0, 0, 0);
                i_in_valid = 1'b0;
                while (pending != 0) @(negedge i_clk);
                write_reg(CFG_INIT_ACC_VAR, accel_vars[ph]);
                send_word(1'b0, ONE_FX, ONE_FX, 0, 0, 0, 0);
                send_word(1'b1, 7 * ONE_FX, -7 * ONE_FX, 0, 0, 0, 0);
                words += 3;
            end
            for (int i = 0; i < WORDS_PER_PHASE - (ph == 0 ? 12 : (ph == 1 ? 3 : 0)); i++) begin
                if (ph == 2 && i == 20) quiet = 1'b1;
                if (ph == 2 && i == 100) quiet = 1'b0;
                if (ph == 3 && i == 10) hold_req = 1'b1;
                random_word();
                words++;
            end
        end
        i_in_valid = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (fail_count == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

endmodule
